// File: rtl/tpll_pkg.sv
`timescale 1ns / 1ps
// Package for the three-phase PLL tracker: widths, constants, the sine ROM,
// configuration register indexes and the stage control bundle.
// Depends on nothing; every other file of the block imports it.
package tpll_pkg;

	// Sine ROM geometry.
	localparam int SINE_TABLE_BITS = 10;
	localparam int TAB_SIZE        = 1 << SINE_TABLE_BITS;
	localparam int QUARTER         = TAB_SIZE >> 2;

	// One third of a turn in Q0.32.
	localparam logic [31:0] THIRD_TURN = 32'd1431655765;

	// Odd polynomial coefficients of the quarter wave, Q30.
	localparam longint PC1 = 64'sd1686629713;
	localparam longint PC3 = 64'sd693598669;
	localparam longint PC5 = 64'sd85569305;
	localparam longint PC7 = 64'sd5026995;
	localparam longint PC9 = 64'sd172272;

	// Field and datapath widths.
	localparam int VOLT_W   = 16;
	localparam int PU_W     = 17;
	localparam int SINE_W   = 16;
	localparam int PROD_W   = 31;
	localparam int SUM_W    = 32;
	localparam int NUM_W    = 34;
	localparam int M_W      = 20;
	localparam int QERR_W   = 16;
	localparam int FREQ_W   = 32;
	localparam int PHASE_W  = 32;
	localparam int PHOUT_W  = 16;

	// Number of register stages between the sample transfer and the commit.
	localparam int NSTAGE   = 9;

	// Floor division by three of a biased, non-negative 20-bit value.
	localparam int          DIV3_SHIFT = 21;
	localparam logic [19:0] DIV3_MULT  = 20'd699051;
	localparam int          DIV3_BIAS  = 786432;
	localparam int          QUO_BIAS   = 262144;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VOLT_RECIP    = 3'd0,
		CFG_KP_GAIN       = 3'd1,
		CFG_KI_GAIN       = 3'd2,
		CFG_NOMINAL_FREQ  = 3'd3,
		CFG_SAMPLE_PERIOD = 3'd4
	} cfg_idx_t;

	// Register reset values.
	localparam logic [15:0] VOLT_RECIP_RST    = 16'd53942;
	localparam logic [27:0] KP_GAIN_RST       = 28'd2317302;
	localparam logic [27:0] KI_GAIN_RST       = 28'd131329;
	localparam logic [23:0] NOMINAL_FREQ_RST  = 24'd3276800;
	localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd4294967;

	// Load enables of the pipeline stages, one per stage.
	typedef struct packed {
		logic scale;    // s1: per-unit scaling and sine lookup
		logic mul;      // s2: lane products
		logic sum;      // s3: lane merge
		logic recip;    // s4: divide-by-three multiply
		logic sat;      // s5: q error saturation
		logic pi;       // s6: PI gain products
		logic corr;     // s7: correction update
		logic freq;     // s8: frequency
		logic step_mul; // s9: phase step products
		logic commit;   // phase update and result load
	} tpll_ctl_t;

	typedef logic signed [SINE_W-1:0] sine_rom_t [TAB_SIZE];

	// Quarter-wave sine, Q14, from the fixed integer polynomial.
	function automatic longint quarter_sine(longint k);
		longint x;
		longint x2;
		longint r;
		x  = k <<< (32 - SINE_TABLE_BITS);
		x2 = (x * x) >>> 30;
		r  = PC7 - ((x2 * PC9) >>> 30);
		r  = PC5 - ((x2 * r) >>> 30);
		r  = PC3 - ((x2 * r) >>> 30);
		r  = PC1 - ((x2 * r) >>> 30);
		r  = (x * r) >>> 30;
		r  = (r + 64'sd32768) >>> 16;
		if (r > 64'sd16384) begin
			r = 64'sd16384;
		end
		return r;
	endfunction

	// Full-turn table built at elaboration from the quarter wave.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint    s;
		int        quad;
		int        k;
		for (int i = 0; i < TAB_SIZE; i++) begin
			quad = i / QUARTER;
			k    = i % QUARTER;
			s    = (quad % 2 == 1) ? quarter_sine(longint'(QUARTER - k))
			                       : quarter_sine(longint'(k));
			if (quad >= 2) begin
				s = -s;
			end
			rom[i] = SINE_W'(s);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Clamp a 34-bit signed value to signed 32 bits.
	function automatic logic signed [31:0] sat32(logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -34'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// File: rtl/tpll_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the PLL tracker: sample input and estimate output.
// Depends on tpll_pkg for the field widths.

interface tpll_sample_if;
	import tpll_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [VOLT_W-1:0] va;
	logic signed [VOLT_W-1:0] vb;
	logic signed [VOLT_W-1:0] vc;

	modport source (output valid, output va, output vb, output vc, input ready);
	modport sink (input valid, input va, input vb, input vc, output ready);
endinterface

interface tpll_est_if;
	import tpll_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [FREQ_W-1:0] freq_est;
	logic [PHOUT_W-1:0]       phase_est;
	logic signed [QERR_W-1:0] q_error;

	modport source (output valid, output freq_est, output phase_est, output q_error,
		input ready);
	modport sink (input valid, input freq_est, input phase_est, input q_error,
		output ready);
endinterface

// File: rtl/tpll_lane.sv
`timescale 1ns / 1ps
// One phase lane: per-unit scaling, sine lookup and the sine-times-voltage product.
// Depends on tpll_pkg (widths, sine ROM, stage control).
module tpll_lane (
	input  logic                               clk,
	input  tpll_pkg::tpll_ctl_t                ctl,
	input  logic signed [tpll_pkg::VOLT_W-1:0] volt,
	input  logic [15:0]                        volt_recip,
	input  logic [tpll_pkg::SINE_TABLE_BITS-1:0] sine_idx,
	output logic signed [tpll_pkg::PROD_W-1:0] prod
);
	import tpll_pkg::*;

	logic signed [32:0]       scaled;
	logic signed [PU_W-1:0]   pu_s1;
	logic signed [SINE_W-1:0] sine_s1;
	logic signed [32:0]       prod_full;
	logic signed [PROD_W-1:0] prod_s2;

	// Round to nearest into Q2.14 per-unit.
	assign scaled = (33'(volt) * $signed({17'd0, volt_recip})) + 33'sd32768;

	always_ff @(posedge clk) begin
		if (ctl.scale) begin
			pu_s1   <= scaled[32:16];
			sine_s1 <= SINE_ROM[sine_idx];
		end
	end

	// Sine (Q1.14) times per-unit (Q2.14); magnitude stays within 2^29.
	assign prod_full = 33'(sine_s1) * 33'(pu_s1);

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s2 <= prod_full[PROD_W-1:0];
		end
	end

	assign prod = prod_s2;

endmodule

// File: rtl/tpll_qerr.sv
`timescale 1ns / 1ps
// Lane merge: sums the three lane products and forms the saturated q error,
// floor((-2*S + 24576) / 49152), as a shift by 14 and a reciprocal divide by three.
// Depends on tpll_pkg.
module tpll_qerr (
	input  logic                               clk,
	input  tpll_pkg::tpll_ctl_t                ctl,
	input  logic signed [tpll_pkg::PROD_W-1:0] prod_a,
	input  logic signed [tpll_pkg::PROD_W-1:0] prod_b,
	input  logic signed [tpll_pkg::PROD_W-1:0] prod_c,
	output logic signed [tpll_pkg::QERR_W-1:0] q_err
);
	import tpll_pkg::*;

	logic signed [SUM_W-1:0]  sum;
	logic signed [NUM_W-1:0]  num;
	logic signed [M_W-1:0]    m_s3;
	logic signed [M_W:0]      biased;
	logic [39:0]              rm_s4;
	logic signed [M_W-1:0]    quo;
	logic signed [QERR_W-1:0] q_s5;

	// Merge the lanes and take the floor of the numerator over 2^14.
	assign sum = SUM_W'(prod_a) + SUM_W'(prod_b) + SUM_W'(prod_c);
	assign num = NUM_W'(24576) - (NUM_W'(sum) <<< 1);

	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			m_s3 <= num[NUM_W-1:NUM_W-M_W];
		end
	end

	// Bias into the non-negative range so a plain reciprocal multiply gives the floor.
	assign biased = (M_W+1)'(m_s3) + (M_W+1)'(DIV3_BIAS);

	always_ff @(posedge clk) begin
		if (ctl.recip) begin
			rm_s4 <= 40'(biased[M_W-1:0]) * 40'(DIV3_MULT);
		end
	end

	// Remove the bias and clamp to signed 16 bits.
	assign quo = $signed({1'b0, rm_s4[39:DIV3_SHIFT]}) - M_W'(QUO_BIAS);

	always_ff @(posedge clk) begin
		if (ctl.sat) begin
			if (quo > M_W'(32767)) begin
				q_s5 <= 16'sh7FFF;
			end else if (quo < -M_W'(32768)) begin
				q_s5 <= 16'sh8000;
			end else begin
				q_s5 <= quo[QERR_W-1:0];
			end
		end
	end

	assign q_err = q_s5;

endmodule

// File: rtl/tpll_loop.sv
`timescale 1ns / 1ps
// Loop filter and oscillator: incremental PI on the q error, frequency as nominal
// plus correction, and the trapezoidal turn accumulator.
// Depends on tpll_pkg.
module tpll_loop (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tpll_pkg::tpll_ctl_t                ctl,
	input  logic signed [tpll_pkg::QERR_W-1:0] q_err,
	input  logic [27:0]                        kp_gain,
	input  logic [27:0]                        ki_gain,
	input  logic [23:0]                        nominal_freq,
	input  logic [31:0]                        sample_period,
	output logic signed [tpll_pkg::FREQ_W-1:0] freq,
	output logic [tpll_pkg::PHASE_W-1:0]       phase_acc,
	output logic [tpll_pkg::PHASE_W-1:0]       phase_next
);
	import tpll_pkg::*;

	logic signed [QERR_W-1:0] last_err_q;
	logic signed [31:0]       corr_q;
	logic signed [31:0]       last_freq_q;
	logic [PHASE_W-1:0]       phase_acc_q;
	logic signed [QERR_W:0]   err_diff;
	logic signed [QERR_W:0]   err_sum;
	logic signed [45:0]       kp_s6;
	logic signed [45:0]       ki_s6;
	logic signed [46:0]       pi_tot;
	logic signed [33:0]       corr_sum;
	logic signed [33:0]       freq_sum;
	logic signed [FREQ_W-1:0] freq_s8;
	logic signed [32:0]       fsum;
	logic signed [49:0]       mhi_s9;
	logic signed [49:0]       mlo_s9;
	logic signed [50:0]       step_tot;
	logic [PHASE_W-1:0]       step;

	// PI gain products on the error difference and the error sum.
	assign err_diff = (QERR_W+1)'(q_err) - (QERR_W+1)'(last_err_q);
	assign err_sum  = (QERR_W+1)'(q_err) + (QERR_W+1)'(last_err_q);

	always_ff @(posedge clk) begin
		if (ctl.pi) begin
			kp_s6 <= $signed({18'd0, kp_gain}) * 46'(err_diff);
			ki_s6 <= $signed({18'd0, ki_gain}) * 46'(err_sum);
		end
	end

	// Rounded increment added to the saturating correction.
	assign pi_tot   = 47'(kp_s6) + 47'(ki_s6) + 47'sd8192;
	assign corr_sum = 34'(corr_q) + 34'($signed(pi_tot[46:14]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q     <= '0;
			last_err_q <= '0;
		end else if (ctl.corr) begin
			corr_q     <= sat32(corr_sum);
			last_err_q <= q_err;
		end
	end

	// Frequency is the nominal value plus the correction.
	assign freq_sum = $signed({10'd0, nominal_freq}) + 34'(corr_q);

	always_ff @(posedge clk) begin
		if (ctl.freq) begin
			freq_s8 <= sat32(freq_sum);
		end
	end

	// Trapezoid of new and previous frequency times the period, split in halves.
	assign fsum = 33'(freq_s8) + 33'(last_freq_q);

	always_ff @(posedge clk) begin
		if (ctl.step_mul) begin
			mhi_s9 <= 50'(fsum) * $signed({34'd0, sample_period[31:16]});
			mlo_s9 <= 50'(fsum) * $signed({34'd0, sample_period[15:0]});
		end
	end

	assign step_tot   = 51'(mhi_s9) + 51'($signed(mlo_s9[49:16])) + (51'sd1 <<< 32);
	assign step       = {{14{step_tot[50]}}, step_tot[50:33]};
	assign phase_next = phase_acc_q + step;

	// The accumulator wraps modulo one turn in either direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			last_freq_q <= '0;
		end else if (ctl.commit) begin
			phase_acc_q <= phase_next;
			last_freq_q <= freq_s8;
		end
	end

	assign freq      = freq_s8;
	assign phase_acc = phase_acc_q;

endmodule

// File: rtl/three_phase_pll_tracker.sv
`timescale 1ns / 1ps
// Top level of the three-phase synchronous-frame PLL tracker: configuration
// registers, stage sequencing, three phase lanes, the merge and the loop.
// Depends on tpll_pkg, tpll_if, tpll_lane, tpll_qerr and tpll_loop.
//
//  Channel    Direction  Transfer payload
//  samples    in         va, vb, vc (signed 1/64 V)
//  estimates  out        freq_est (Q16.16 Hz), phase_est (turns, top 16), q_error (Q1.14)
//  cfg        in         cfg_wr_en, cfg_index, cfg_data (write only)
//
// One sample at a time flows through nine register stages; its result is
// then loaded into the output register, and a new sample is taken only once
// the previous result has been loaded there.
// The stage chain is set by the serial dependence q error -> PI -> frequency -> phase.
// A stalled output holds the last stage, and the phase update, until a slot frees.
// Reset clears the loop state and loads the register defaults.
module three_phase_pll_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tpll_sample_if.sink                          samples,
	tpll_est_if.source                           estimates,
	input  logic                                 cfg_wr_en,
	input  logic [tpll_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpll_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tpll_pkg::*;

	logic [15:0]              volt_recip_q;
	logic [27:0]              kp_gain_q;
	logic [27:0]              ki_gain_q;
	logic [23:0]              nominal_freq_q;
	logic [31:0]              sample_period_q;

	logic [NSTAGE-1:0]        vld_q;
	logic                     in_xfer;
	logic                     out_free;
	tpll_ctl_t                ctl;

	logic [PHASE_W-1:0]       phase_acc;
	logic [PHASE_W-1:0]       phase_next;
	logic [PHASE_W-1:0]       angle_b;
	logic [PHASE_W-1:0]       angle_c;
	logic signed [PROD_W-1:0] prod_a;
	logic signed [PROD_W-1:0] prod_b;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [QERR_W-1:0] q_err;
	logic signed [FREQ_W-1:0] freq;

	logic                     out_valid_q;
	logic signed [FREQ_W-1:0] freq_out_q;
	logic [PHOUT_W-1:0]       phase_out_q;
	logic signed [QERR_W-1:0] qerr_out_q;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_recip_q    <= VOLT_RECIP_RST;
			kp_gain_q       <= KP_GAIN_RST;
			ki_gain_q       <= KI_GAIN_RST;
			nominal_freq_q  <= NOMINAL_FREQ_RST;
			sample_period_q <= SAMPLE_PERIOD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_VOLT_RECIP:    volt_recip_q    <= cfg_data[15:0];
				CFG_KP_GAIN:       kp_gain_q       <= cfg_data[27:0];
				CFG_KI_GAIN:       ki_gain_q       <= cfg_data[27:0];
				CFG_NOMINAL_FREQ:  nominal_freq_q  <= cfg_data[23:0];
				CFG_SAMPLE_PERIOD: sample_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: one sample in flight; the output register parts the two sides.
	assign samples.ready = ~|vld_q;
	assign in_xfer       = samples.valid & samples.ready;
	assign out_free      = ~out_valid_q | estimates.ready;

	// Stage valid chain; the last stage waits for a free output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q[0] <= in_xfer;
			for (int k = 1; k < NSTAGE - 1; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			vld_q[NSTAGE-1] <= vld_q[NSTAGE-2] | (vld_q[NSTAGE-1] & ~out_free);
		end
	end

	// Stage load enables.
	always_comb begin
		ctl.scale    = in_xfer;
		ctl.mul      = vld_q[0];
		ctl.sum      = vld_q[1];
		ctl.recip    = vld_q[2];
		ctl.sat      = vld_q[3];
		ctl.pi       = vld_q[4];
		ctl.corr     = vld_q[5];
		ctl.freq     = vld_q[6];
		ctl.step_mul = vld_q[7];
		ctl.commit   = vld_q[8] & out_free;
	end

	// Lane angles: theta, theta minus and plus a third of a turn.
	assign angle_b = phase_acc - THIRD_TURN;
	assign angle_c = phase_acc + THIRD_TURN;

	tpll_lane u_lane_a (
		.clk        (clk),
		.ctl        (ctl),
		.volt       (samples.va),
		.volt_recip (volt_recip_q),
		.sine_idx   (phase_acc[PHASE_W-1 -: SINE_TABLE_BITS]),
		.prod       (prod_a)
	);

	tpll_lane u_lane_b (
		.clk        (clk),
		.ctl        (ctl),
		.volt       (samples.vb),
		.volt_recip (volt_recip_q),
		.sine_idx   (angle_b[PHASE_W-1 -: SINE_TABLE_BITS]),
		.prod       (prod_b)
	);

	tpll_lane u_lane_c (
		.clk        (clk),
		.ctl        (ctl),
		.volt       (samples.vc),
		.volt_recip (volt_recip_q),
		.sine_idx   (angle_c[PHASE_W-1 -: SINE_TABLE_BITS]),
		.prod       (prod_c)
	);

	tpll_qerr u_qerr (
		.clk    (clk),
		.ctl    (ctl),
		.prod_a (prod_a),
		.prod_b (prod_b),
		.prod_c (prod_c),
		.q_err  (q_err)
	);

	tpll_loop u_loop (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.q_err         (q_err),
		.kp_gain       (kp_gain_q),
		.ki_gain       (ki_gain_q),
		.nominal_freq  (nominal_freq_q),
		.sample_period (sample_period_q),
		.freq          (freq),
		.phase_acc     (phase_acc),
		.phase_next    (phase_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (estimates.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			freq_out_q  <= freq;
			phase_out_q <= phase_next[PHASE_W-1 -: PHOUT_W];
			qerr_out_q  <= q_err;
		end
	end

	assign estimates.valid     = out_valid_q;
	assign estimates.freq_est  = freq_out_q;
	assign estimates.phase_est = phase_out_q;
	assign estimates.q_error   = qerr_out_q;

	// At most one sample is ever inside the stage chain.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_q))
		else $error("more than one sample in the stage chain");

	// A sample transfer starts the chain at its first stage only.
	a_xfer_starts_chain: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (vld_q == NSTAGE'(1)))
		else $error("stage chain did not start cleanly after a transfer");

	// A finished sample waiting on a full output slot stays put.
	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTAGE-1] && !out_free) |=> vld_q[NSTAGE-1])
		else $error("last stage dropped while output was full");

	// No result is loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !estimates.ready) |-> !ctl.commit)
		else $error("output register overwritten");

endmodule
